>>> src/ffha_pkg.sv
// Package for the first-fit heap allocator: payload types, opcodes, status codes.
// Used by every module under src.
`timescale 1ns / 1ps
package ffha_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int ALIGN_BYTES_DEF  = 16;

    localparam logic [31:0] RESET_BASE  = 32'h0020_0000;
    localparam logic [31:0] RESET_BYTES = 32'h03F0_0000 - 32'h0020_0000;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_INIT  = 2'd2;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_ZERO     = 3'd1;
    localparam logic [2:0] ST_OVERFLOW = 3'd2;
    localparam logic [2:0] ST_NO_FIT   = 3'd3;
    localparam logic [2:0] ST_NOT_BLK  = 3'd4;
    localparam logic [2:0] ST_DBL_FREE = 3'd5;
    localparam logic [2:0] ST_IGNORED  = 3'd6;

    localparam logic CFG_HEAP_BASE  = 1'b0;
    localparam logic CFG_HEAP_BYTES = 1'b1;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] request_bytes;
        logic [31:0] release_addr;
    } ffha_in_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] data_addr;
        logic [31:0] used_bytes;
        logic [31:0] alloc_total;
        logic [31:0] free_total;
        logic [6:0]  free_segs;
    } ffha_out_t;

endpackage

>>> src/ffha_seg_table.sv
// Segment table memory: start, size and used flag per entry; one read, one write port.
// Depends on ffha_pkg.
`timescale 1ns / 1ps
module ffha_seg_table
    import ffha_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    localparam int IW = $clog2(MAX_SEGMENTS)
)
(
    input  logic          clk,
    input  logic [IW-1:0] raddr,
    output logic [31:0]   rstart,
    output logic [31:0]   rsize,
    output logic          rused,
    input  logic          we,
    input  logic [IW-1:0] waddr,
    input  logic [31:0]   wstart,
    input  logic [31:0]   wsize,
    input  logic          wused
);

    logic [64:0] mem [MAX_SEGMENTS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= {wused, wsize, wstart};
        end
        {rused, rsize, rstart} <= mem[raddr];
    end

endmodule

>>> src/first_fit_heap_allocator.sv
// Top level of the first-fit heap allocator: sequencer, statistics, result register.
// Depends on ffha_pkg and ffha_seg_table.
//
//  channel | signals                            | direction
//  --------+------------------------------------+----------
//  in      | in_valid, in_ready, in_data        | item in
//  out     | out_valid, out_ready, out_data     | item out
//  cfg     | cfg_we, cfg_index, cfg_data        | register write
//
// One item at a time; the table is walked one entry per memory read, set by the
// single read port of the segment table. Zero, overflow, null, unused-opcode and
// reinitialise items are settled in S_DEC and go straight to S_DONE without a
// table read; a split shifts the entries above the hit one place right and each
// merge shifts them one place left, with a read state and a write state per entry.
// After reset, and on reinitialise, entry 0 is written before the first item is
// accepted. in_ready is low while an item is in work or its result waits on
// out_ready.
`timescale 1ns / 1ps
module first_fit_heap_allocator
    import ffha_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF,
    parameter int HEADER_BYTES = HEADER_BYTES_DEF,
    parameter int ALIGN_BYTES  = ALIGN_BYTES_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  ffha_in_t   in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output ffha_out_t  out_data,
    input  logic       cfg_we,
    input  logic       cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = IW + 1;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_SEGMENTS);
    localparam logic [32:0] HDR33 = 33'(HEADER_BYTES);
    localparam logic [32:0] ALM33 = 33'(ALIGN_BYTES - 1);
    localparam logic [31:0] HDR32 = 32'(HEADER_BYTES);
    localparam logic [32:0] SPLIT_MIN = 33'(HEADER_BYTES + ALIGN_BYTES);

    typedef enum logic [3:0] {
        S_INIT, S_IDLE, S_DEC, S_RD, S_CHK, S_SHR_RD, S_SHR_WR,
        S_SPLIT, S_FREE_NXT, S_FREE_PRV, S_SHL_RD, S_SHL_WR, S_DONE
    } state_t;

    state_t         state_reg, state_next;
    logic [31:0]    base_reg, bytes_reg;
    logic [CW-1:0]  count_reg, count_next;
    logic [31:0]    used_reg, used_next;
    logic [31:0]    allocs_reg, allocs_next;
    logic [31:0]    frees_reg, frees_next;
    logic [CW-1:0]  frags_reg, frags_next;
    logic [CW-1:0]  idx_reg, idx_next;       // scan / shift cursor
    logic [CW-1:0]  hit_reg, hit_next;       // chosen entry
    logic           merge_prv_reg, merge_prv_next;
    logic [31:0]    need_reg, need_next;
    logic [31:0]    acc_size_reg, acc_size_next; // size of merged segment or of split remainder
    logic [31:0]    hit_start_reg, hit_start_next;
    logic [31:0]    prv_size_reg, prv_size_next;
    logic           prv_free_reg, prv_free_next;
    logic [31:0]    prv_start_reg;           // start of the entry before the hit
    ffha_in_t       item_reg, item_next;
    ffha_out_t      res_reg, res_next;
    logic           out_valid_reg, out_valid_next;

    logic [IW-1:0]  raddr, waddr;
    logic [31:0]    rstart, rsize, wstart, wsize;
    logic           rused, we, wused;

    logic [32:0]    need33;
    logic [32:0]    rest33;
    logic [31:0]    blk;

    ffha_seg_table #(.MAX_SEGMENTS(MAX_SEGMENTS)) u_table (
        .clk(clk), .raddr(raddr), .rstart(rstart), .rsize(rsize), .rused(rused),
        .we(we), .waddr(waddr), .wstart(wstart), .wsize(wsize), .wused(wused)
    );

    // request plus header, rounded up to the alignment; 33 bits to catch overflow
    assign need33 = (({1'b0, item_reg.request_bytes} + HDR33 + ALM33)
                     & ~ALM33);
    assign rest33 = {1'b0, rsize} - {1'b0, need_reg};
    assign blk    = item_reg.release_addr - HDR32;

    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = res_reg;

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        used_next      = used_reg;
        allocs_next    = allocs_reg;
        frees_next     = frees_reg;
        frags_next     = frags_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        merge_prv_next = merge_prv_reg;
        need_next      = need_reg;
        acc_size_next  = acc_size_reg;
        hit_start_next = hit_start_reg;
        prv_size_next  = prv_size_reg;
        prv_free_next  = prv_free_reg;
        item_next      = item_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg;
        raddr = idx_reg[IW-1:0];
        we    = 1'b0;
        waddr = idx_reg[IW-1:0];
        wstart = rstart;
        wsize  = rsize;
        wused  = rused;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_INIT:
            begin
                we = 1'b1;
                waddr = '0;
                wstart = base_reg;
                wsize = bytes_reg;
                wused = 1'b0;
                count_next = CW'(1);
                frags_next = CW'(1);
                used_next = '0;
                allocs_next = '0;
                frees_next = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    item_next = in_data;
                    state_next = S_DEC;
                end
            end
            S_DEC:
            begin
                res_next.data_addr = '0;
                res_next.status = ST_OK;
                idx_next = '0;
                prv_free_next = 1'b0;
                state_next = S_DONE;
                case (item_reg.opcode)
                    OP_ALLOC:
                    begin
                        need_next = need33[31:0];
                        if (item_reg.request_bytes == '0)
                            res_next.status = ST_ZERO;
                        else if (need33[32])
                            res_next.status = ST_OVERFLOW;
                        else
                            state_next = S_RD;
                    end
                    OP_FREE:
                    begin
                        if (item_reg.release_addr == '0)
                            res_next.status = ST_IGNORED;
                        else
                            state_next = S_RD;
                    end
                    OP_INIT:
                    begin
                        we = 1'b1;
                        waddr = '0;
                        wstart = base_reg;
                        wsize = bytes_reg;
                        wused = 1'b0;
                        count_next = CW'(1);
                        frags_next = CW'(1);
                        used_next = '0;
                        allocs_next = '0;
                        frees_next = '0;
                    end
                    default: res_next.status = ST_IGNORED;
                endcase
            end
            S_RD:
            begin
                // address presented; data valid next cycle
                if (idx_reg >= count_reg)
                begin
                    res_next.status = (item_reg.opcode == OP_ALLOC) ? ST_NO_FIT
                                                                   : ST_NOT_BLK;
                    state_next = S_DONE;
                end
                else
                begin
                    state_next = S_CHK;
                end
            end
            S_CHK:
            begin
                hit_next = idx_reg;
                hit_start_next = rstart;
                acc_size_next = rsize;
                idx_next = idx_reg + CW'(1);
                state_next = S_RD;
                if (item_reg.opcode == OP_ALLOC)
                begin
                    if (!rused && rsize >= need_reg)
                    begin
                        allocs_next = allocs_reg + 32'd1;
                        res_next.data_addr = rstart + HDR32;
                        if (rest33 >= SPLIT_MIN && count_reg < MAX_CNT)
                        begin
                            used_next = used_reg + need_reg;
                            we = 1'b1;
                            waddr = idx_reg[IW-1:0];
                            wsize = need_reg;
                            wused = 1'b1;
                            acc_size_next = rest33[31:0];
                            hit_start_next = rstart + need_reg;
                            count_next = count_reg + CW'(1);
                            idx_next = count_reg;   // shift right from the top
                            state_next = (count_reg == idx_reg + CW'(1)) ? S_SPLIT
                                                                         : S_SHR_RD;
                        end
                        else
                        begin
                            used_next = used_reg + rsize;
                            frags_next = frags_reg - CW'(1);
                            we = 1'b1;
                            wused = 1'b1;
                            state_next = S_DONE;
                        end
                    end
                end
                else
                begin
                    if (rstart == blk)
                    begin
                        if (rused)
                        begin
                            used_next = used_reg - rsize;
                            frees_next = frees_reg + 32'd1;
                            frags_next = frags_reg + CW'(1);
                            raddr = IW'(idx_reg + CW'(1));   // following entry
                            state_next = S_FREE_NXT;
                        end
                        else
                        begin
                            res_next.status = ST_DBL_FREE;
                            state_next = S_DONE;
                        end
                    end
                    else
                    begin
                        prv_free_next = !rused;
                        prv_size_next = rsize;
                    end
                end
            end
            S_SHR_RD:
            begin
                raddr = IW'(idx_reg - CW'(1));
                state_next = S_SHR_WR;
            end
            S_SHR_WR:
            begin
                we = 1'b1;
                waddr = idx_reg[IW-1:0];
                idx_next = idx_reg - CW'(1);
                state_next = (idx_reg - CW'(1) == hit_reg + CW'(1)) ? S_SPLIT
                                                                    : S_SHR_RD;
            end
            S_SPLIT:
            begin
                we = 1'b1;
                waddr = IW'(hit_reg + CW'(1));
                wstart = hit_start_reg;
                wsize = acc_size_reg;
                wused = 1'b0;
                state_next = S_DONE;
            end
            S_FREE_NXT:
            begin
                // idx_reg = hit+1 was presented in S_CHK
                merge_prv_next = 1'b0;
                if (idx_reg < count_reg && !rused)
                begin
                    acc_size_next = acc_size_reg + rsize;
                    frags_next = frags_reg - CW'(1);
                    merge_prv_next = 1'b1;   // marks: then check previous
                    state_next = S_SHL_RD;
                    idx_next = idx_reg + CW'(1);
                end
                else
                begin
                    state_next = S_FREE_PRV;
                end
                if (!(idx_reg < count_reg && !rused))
                begin
                    we = 1'b1;
                    waddr = hit_reg[IW-1:0];
                    wstart = hit_start_reg;
                    wsize = acc_size_reg;
                    wused = 1'b0;
                end
            end
            S_FREE_PRV:
            begin
                merge_prv_next = 1'b0;
                if (hit_reg != '0 && prv_free_reg)
                begin
                    frags_next = frags_reg - CW'(1);
                    we = 1'b1;
                    waddr = IW'(hit_reg - CW'(1));
                    wstart = prv_start_reg;
                    wsize = prv_size_reg + acc_size_reg;
                    wused = 1'b0;
                    idx_next = hit_reg + CW'(1);
                    state_next = S_SHL_RD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_SHL_RD:
            begin
                if (idx_reg >= count_reg)
                begin
                    count_next = count_reg - CW'(1);
                    if (merge_prv_reg)
                    begin
                        we = 1'b1;
                        waddr = hit_reg[IW-1:0];
                        wstart = hit_start_reg;
                        wsize = acc_size_reg;
                        wused = 1'b0;
                        state_next = S_FREE_PRV;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
                else
                begin
                    state_next = S_SHL_WR;
                end
            end
            S_SHL_WR:
            begin
                we = 1'b1;
                waddr = IW'(idx_reg - CW'(1));
                idx_next = idx_reg + CW'(1);
                state_next = S_SHL_RD;
            end
            S_DONE:
            begin
                if (!out_valid_reg)
                begin
                    res_next.used_bytes = used_next;
                    res_next.alloc_total = allocs_next;
                    res_next.free_total = frees_next;
                    res_next.free_segs = 7'(frags_reg);
                    out_valid_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // The scan stops at the hit, so the last entry that did not match is the one
    // before it; its start is kept for the merge with the preceding segment.
    always_ff @(posedge clk)
    begin
        if (state_reg == S_CHK && !(rstart == blk))
            prv_start_reg <= rstart;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            base_reg      <= RESET_BASE;
            bytes_reg     <= RESET_BYTES;
            count_reg     <= CW'(1);
            used_reg      <= '0;
            allocs_reg    <= '0;
            frees_reg     <= '0;
            frags_reg     <= CW'(1);
            out_valid_reg <= 1'b0;
            merge_prv_reg <= 1'b0;
            idx_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            used_reg      <= used_next;
            allocs_reg    <= allocs_next;
            frees_reg     <= frees_next;
            frags_reg     <= frags_next;
            out_valid_reg <= out_valid_next;
            merge_prv_reg <= merge_prv_next;
            idx_reg       <= idx_next;
            if (cfg_we && cfg_index == CFG_HEAP_BASE)
                base_reg <= cfg_data;
            if (cfg_we && cfg_index == CFG_HEAP_BYTES)
                bytes_reg <= cfg_data;
        end
    end

    always_ff @(posedge clk)
    begin
        hit_reg       <= hit_next;
        need_reg      <= need_next;
        acc_size_reg  <= acc_size_next;
        hit_start_reg <= hit_start_next;
        prv_size_reg  <= prv_size_next;
        prv_free_reg  <= prv_free_next;
        item_reg      <= item_next;
        res_reg       <= res_next;
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != '0 && count_reg <= MAX_CNT)
        else $error("segment count out of range");
    a_frags_le_count: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> frags_reg <= count_reg)
        else $error("more free fragments than segments");
    a_busy_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> !in_ready)
        else $error("ready while busy");
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == S_DEC)
        else $error("accepted item not decoded");
`endif

endmodule
